// ===== rtl/core/vpma_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Voxel moment accumulator package
// Shared constants, codes and arithmetic helpers for the accumulator and its
// divider.
// ---------------------------------------------------------------------------
package vpma_pkg;

  // Default sizes
  localparam int unsigned NUM_VOXELS_DEF = 4096;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Field and accumulator widths
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned LEAF_W     = 24;
  localparam int unsigned ORG_W      = 16;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned MINP_W     = 16;
  localparam int unsigned VIDX_W     = 12;
  localparam int unsigned SUM1_W     = 40;
  localparam int unsigned SUM2_W     = 64;
  localparam int unsigned MEAN_W     = 24;
  localparam int unsigned COV_W      = 48;
  localparam int unsigned CNT_OUT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned N_AXES     = 3;
  localparam int unsigned N_TERMS    = 6;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_LEAF   = 3'd0,
    CFG_ORIGIN_X   = 3'd1,
    CFG_ORIGIN_Y   = 3'd2,
    CFG_ORIGIN_Z   = 3'd3,
    CFG_DIM_X      = 3'd4,
    CFG_DIM_Y      = 3'd5,
    CFG_DIM_Z      = 3'd6,
    CFG_MIN_POINTS = 3'd7
  } cfg_idx_e;

  // Request operations
  typedef enum logic [0:0] {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ACC_MUL,
    ST_ACC_IDX1,
    ST_ACC_IDX2,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_RD,
    ST_RD_LOAD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_PROD,
    ST_S2_WAIT,
    ST_D_GO,
    ST_D_WAIT,
    ST_OUT
  } state_e;

  // First and second axis of each product term: xx, xy, xz, yy, yz, zz.
  function automatic int unsigned term_a(input int unsigned k);
    int unsigned r;
    r = (k < 3) ? 0 : ((k < 5) ? 1 : 2);
    return r;
  endfunction

  function automatic int unsigned term_b(input int unsigned k);
    int unsigned r;
    case (k)
      0: r = 0;
      1: r = 1;
      3: r = 1;
      default: r = 2;
    endcase
    return r;
  endfunction

  // Saturate a 64-bit value to the mean width.
  function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [SUM2_W-1:0] v);
    logic signed [SUM2_W-1:0] hi;
    logic signed [SUM2_W-1:0] lo;
    logic signed [MEAN_W-1:0] r;
    hi = {{(SUM2_W-MEAN_W+1){1'b0}}, {(MEAN_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) r = hi[MEAN_W-1:0];
    else if (v < lo) r = lo[MEAN_W-1:0];
    else r = v[MEAN_W-1:0];
    return r;
  endfunction

  // Saturate a 64-bit value to the covariance width.
  function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [SUM2_W-1:0] v);
    logic signed [SUM2_W-1:0] hi;
    logic signed [SUM2_W-1:0] lo;
    logic signed [COV_W-1:0] r;
    hi = {{(SUM2_W-COV_W+1){1'b0}}, {(COV_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) r = hi[COV_W-1:0];
    else if (v < lo) r = lo[COV_W-1:0];
    else r = v[COV_W-1:0];
    return r;
  endfunction

  // Clamp to plus or minus 2^62.
  function automatic logic signed [SUM2_W-1:0] clamp62(input logic signed [SUM2_W-1:0] v);
    logic signed [SUM2_W-1:0] lim;
    logic signed [SUM2_W-1:0] r;
    lim = {2'b01, {(SUM2_W-2){1'b0}}};
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

// ===== rtl/core/vpma_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module vpma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/vpma_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Floor divider
// Signed 64-bit dividend by an unsigned nonzero count, one quotient bit per
// cycle, result rounded toward minus infinity.
// ---------------------------------------------------------------------------
module vpma_div import vpma_pkg::*; #(
  parameter int unsigned DVS_W = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SUM2_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic signed [SUM2_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(SUM2_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q;
  logic [SUM2_W-1:0] quo_q;
  logic [DVS_W-1:0]  rem_q;

  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_nx;
  logic              ge;
  logic [SUM2_W-1:0] mag;
  logic [SUM2_W-1:0] quo_up;

  // One restoring step.
  always_comb begin
    rem_sh = {rem_q, quo_q[SUM2_W-1]};
    ge     = (rem_sh >= {1'b0, divisor_i});
    rem_nx = ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
    mag    = dividend_i[SUM2_W-1] ? (-dividend_i) : dividend_i;
  end

  // Negative dividends round the magnitude quotient up before negation.
  always_comb begin
    quo_up     = quo_q + {{(SUM2_W-1){1'b0}}, (rem_q != '0)};
    quotient_o = neg_q ? signed'(-quo_up) : signed'(quo_q);
  end

  assign done_o = done_q;

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SUM2_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM2_W-1];
      quo_q <= mag;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM2_W-2:0], ge};
      rem_q <= rem_nx[DVS_W-1:0];
    end
  end

endmodule

// ===== rtl/core/voxel_point_moment_accumulator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Voxel point moment accumulator
// Bins Q15.8 points into a voxel grid and keeps count, sums and product sums
// per voxel in one RAM; a read request returns mean and covariance and clears.
// ---------------------------------------------------------------------------
// A point passes through the multiply, the index steps, a RAM read and the
// write-back before the next request is taken; a dropped point skips the
// write-back. A read of a valid voxel runs 15 divisions, one at a time, on the
// shared divider; an invalid or empty voxel goes straight to the output.
// A stalled result holds the sequencer until it is taken.
// Reset: configuration registers return to defaults, then a clearing pass
// zeroes all NUM_VOXELS RAM words while requests are stalled.
module voxel_point_moment_accumulator import vpma_pkg::*; #(
  parameter int unsigned NUM_VOXELS = NUM_VOXELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // Request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     operation_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic [VIDX_W-1:0]        voxel_index_i,
  // Result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [MEAN_W-1:0] mean_x_o,
  output logic signed [MEAN_W-1:0] mean_y_o,
  output logic signed [MEAN_W-1:0] mean_z_o,
  output logic signed [COV_W-1:0]  cov_xx_o,
  output logic signed [COV_W-1:0]  cov_xy_o,
  output logic signed [COV_W-1:0]  cov_xz_o,
  output logic signed [COV_W-1:0]  cov_yy_o,
  output logic signed [COV_W-1:0]  cov_yz_o,
  output logic signed [COV_W-1:0]  cov_zz_o,
  output logic [CNT_OUT_W-1:0]     point_count_o,
  output logic                     voxel_valid_o
);

  localparam int unsigned AW     = (NUM_VOXELS > 1) ? $clog2(NUM_VOXELS) : 1;
  localparam int unsigned S1_OFF = COUNT_BITS;
  localparam int unsigned S2_OFF = COUNT_BITS + N_AXES * SUM1_W;
  localparam int unsigned WORD_W = S2_OFF + N_TERMS * SUM2_W;
  localparam int unsigned T_W    = 2 * DIM_W + 1;
  localparam int unsigned IDX_W  = DIM_W + T_W + 1;
  localparam int unsigned CP_W   = COORD_W + LEAF_W + 1;
  localparam int unsigned C_W    = COORD_W + 2;
  localparam int unsigned SQ_W   = 2 * COORD_W;
  localparam int unsigned K_W    = 3;

  // Configuration registers
  logic [LEAF_W-1:0]        inv_leaf_q;
  logic signed [ORG_W-1:0]  org_x_q, org_y_q, org_z_q;
  logic [DIM_W-1:0]         dim_x_q, dim_y_q, dim_z_q;
  logic [MINP_W-1:0]        min_pts_q;

  state_e state_q, state_d;

  // Request and working registers
  logic signed [COORD_W-1:0] pt_q [N_AXES];
  logic [AW-1:0]             addr_q;
  logic                      rng_q;
  logic signed [CP_W-1:0]    cprod_q [N_AXES];
  logic signed [SQ_W-1:0]    sq_q [N_TERMS];
  logic [DIM_W-1:0]          cx_q;
  logic [T_W-1:0]            t_q;
  logic                      inr_q;
  logic                      ok_q;
  logic [AW-1:0]             clr_q;
  logic [K_W-1:0]            k_q;
  logic [COUNT_BITS-1:0]     ent_cnt_q;
  logic [SUM1_W-1:0]         ent_s1_q [N_AXES];
  logic [SUM2_W-1:0]         ent_s2_q [N_TERMS];
  logic signed [MEAN_W-1:0]  mean_q [N_AXES];
  logic signed [SQ_W-1:0]    prod_q;
  logic signed [SUM2_W-1:0]  d_q;
  logic signed [COV_W-1:0]   cov_q [N_TERMS];
  logic [CNT_OUT_W-1:0]      res_cnt_q;
  logic                      res_valid_q;

  // Output registers
  logic                      out_valid_q;
  logic signed [MEAN_W-1:0]  out_mean_q [N_AXES];
  logic signed [COV_W-1:0]   out_cov_q [N_TERMS];
  logic [CNT_OUT_W-1:0]      out_cnt_q;
  logic                      out_vld_q;

  // RAM and divider connections
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr;
  logic [WORD_W-1:0]         ram_wdata, ram_rdata, upd_word;
  logic                      div_start, div_done;
  logic signed [SUM2_W-1:0]  div_dvd, div_quo;

  // Combinational helpers
  logic                      acc_req, out_free;
  logic signed [C_W-1:0]     c_x, c_y, c_z;
  logic                      in_x, in_y, in_z;
  logic [IDX_W-1:0]          idx;
  logic [31:0]               vidx_ext;
  logic [COUNT_BITS-1:0]     rd_cnt;
  logic                      rd_full, ld_valid;
  logic signed [MEAN_W-1:0]  ma, mb;
  logic [SUM1_W-1:0]         s1_sel;
  logic [SUM2_W-1:0]         s2_sel;

  assign in_stall_o = (state_q != ST_IDLE);
  assign acc_req    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign vidx_ext   = 32'(voxel_index_i);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_leaf_q <= LEAF_W'(65536);
      org_x_q    <= '0;
      org_y_q    <= '0;
      org_z_q    <= '0;
      dim_x_q    <= DIM_W'(16);
      dim_y_q    <= DIM_W'(16);
      dim_z_q    <= DIM_W'(16);
      min_pts_q  <= MINP_W'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INV_LEAF:   inv_leaf_q <= cfg_data_i[LEAF_W-1:0];
        CFG_ORIGIN_X:   org_x_q    <= signed'(cfg_data_i[ORG_W-1:0]);
        CFG_ORIGIN_Y:   org_y_q    <= signed'(cfg_data_i[ORG_W-1:0]);
        CFG_ORIGIN_Z:   org_z_q    <= signed'(cfg_data_i[ORG_W-1:0]);
        CFG_DIM_X:      dim_x_q    <= cfg_data_i[DIM_W-1:0];
        CFG_DIM_Y:      dim_y_q    <= cfg_data_i[DIM_W-1:0];
        CFG_DIM_Z:      dim_z_q    <= cfg_data_i[DIM_W-1:0];
        CFG_MIN_POINTS: min_pts_q  <= cfg_data_i[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  // Voxel coordinates, range checks and the flat index.
  always_comb begin
    c_x  = C_W'(cprod_q[0] >>> LEAF_W) - C_W'(org_x_q);
    c_y  = C_W'(cprod_q[1] >>> LEAF_W) - C_W'(org_y_q);
    c_z  = C_W'(cprod_q[2] >>> LEAF_W) - C_W'(org_z_q);
    in_x = !c_x[C_W-1] && (c_x[C_W-2:0] < (C_W-1)'(dim_x_q));
    in_y = !c_y[C_W-1] && (c_y[C_W-2:0] < (C_W-1)'(dim_y_q));
    in_z = !c_z[C_W-1] && (c_z[C_W-2:0] < (C_W-1)'(dim_z_q));
    idx  = IDX_W'(cx_q) + IDX_W'(dim_x_q) * IDX_W'(t_q);
  end

  // Read word fields and the accumulated update.
  always_comb begin
    rd_cnt   = ram_rdata[COUNT_BITS-1:0];
    rd_full  = (rd_cnt == {COUNT_BITS{1'b1}});
    ld_valid = (32'(rd_cnt) >= 32'(min_pts_q));
    upd_word = '0;
    upd_word[COUNT_BITS-1:0] = rd_cnt + 1'b1;
    for (int j = 0; j < N_AXES; j++) begin
      upd_word[S1_OFF + SUM1_W*j +: SUM1_W] = ram_rdata[S1_OFF + SUM1_W*j +: SUM1_W]
        + {{(SUM1_W-COORD_W){pt_q[j][COORD_W-1]}}, pt_q[j]};
    end
    for (int j = 0; j < N_TERMS; j++) begin
      upd_word[S2_OFF + SUM2_W*j +: SUM2_W] = ram_rdata[S2_OFF + SUM2_W*j +: SUM2_W]
        + {{(SUM2_W-SQ_W){sq_q[j][SQ_W-1]}}, sq_q[j]};
    end
  end

  // Term selection for the current step.
  always_comb begin
    unique case (k_q)
      3'd0: begin ma = mean_q[0]; mb = mean_q[0]; s1_sel = ent_s1_q[0]; s2_sel = ent_s2_q[0]; end
      3'd1: begin ma = mean_q[0]; mb = mean_q[1]; s1_sel = ent_s1_q[1]; s2_sel = ent_s2_q[1]; end
      3'd2: begin ma = mean_q[0]; mb = mean_q[2]; s1_sel = ent_s1_q[2]; s2_sel = ent_s2_q[2]; end
      3'd3: begin ma = mean_q[1]; mb = mean_q[1]; s1_sel = ent_s1_q[0]; s2_sel = ent_s2_q[3]; end
      3'd4: begin ma = mean_q[1]; mb = mean_q[2]; s1_sel = ent_s1_q[0]; s2_sel = ent_s2_q[4]; end
      3'd5: begin ma = mean_q[2]; mb = mean_q[2]; s1_sel = ent_s1_q[0]; s2_sel = ent_s2_q[5]; end
      default: begin ma = '0; mb = '0; s1_sel = '0; s2_sel = '0; end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (acc_req) state_d = (op_e'(operation_i) == OP_ACCUM) ? ST_ACC_MUL : ST_RD_RD;
      ST_CLEAR:     if (clr_q == AW'(NUM_VOXELS - 1)) state_d = ST_IDLE;
      ST_ACC_MUL:   state_d = ST_ACC_IDX1;
      ST_ACC_IDX1:  state_d = ST_ACC_IDX2;
      ST_ACC_IDX2:  state_d = ST_ACC_RD;
      ST_ACC_RD:    state_d = ok_q ? ST_ACC_WR : ST_IDLE;
      ST_ACC_WR:    state_d = ST_IDLE;
      ST_RD_RD:     state_d = rng_q ? ST_RD_LOAD : ST_OUT;
      ST_RD_LOAD:   state_d = (ld_valid && (rd_cnt != '0)) ? ST_MEAN_GO : ST_OUT;
      ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_done) state_d = (k_q == K_W'(N_AXES - 1)) ? ST_PROD : ST_MEAN_GO;
      ST_PROD:      state_d = ST_S2_WAIT;
      ST_S2_WAIT:   if (div_done) state_d = ST_D_GO;
      ST_D_GO:      state_d = ST_D_WAIT;
      ST_D_WAIT:    if (div_done) state_d = (k_q == K_W'(N_TERMS - 1)) ? ST_OUT : ST_PROD;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // RAM and divider controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      ST_ACC_RD:  ram_re = ok_q;
      ST_ACC_WR: begin
        ram_we    = !rd_full;
        ram_wdata = upd_word;
      end
      ST_RD_RD:   ram_re = rng_q;
      ST_RD_LOAD: ram_we = 1'b1;
      ST_MEAN_GO: begin
        div_start = 1'b1;
        div_dvd   = signed'({{(SUM2_W-SUM1_W){s1_sel[SUM1_W-1]}}, s1_sel});
      end
      ST_PROD: begin
        div_start = 1'b1;
        div_dvd   = signed'(s2_sel);
      end
      ST_D_GO: begin
        div_start = 1'b1;
        div_dvd   = -d_q;
      end
      default: ;
    endcase
  end

  // Sequencer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if ((state_q == ST_OUT) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (acc_req) begin
        pt_q[0]  <= point_x_i;
        pt_q[1]  <= point_y_i;
        pt_q[2]  <= point_z_i;
        addr_q   <= vidx_ext[AW-1:0];
        rng_q    <= (vidx_ext < 32'(NUM_VOXELS));
      end
      ST_ACC_MUL: begin
        for (int j = 0; j < N_AXES; j++) begin
          cprod_q[j] <= pt_q[j] * signed'({1'b0, inv_leaf_q});
        end
        for (int j = 0; j < N_TERMS; j++) begin
          sq_q[j] <= pt_q[term_a(j)] * pt_q[term_b(j)];
        end
      end
      ST_ACC_IDX1: begin
        inr_q <= in_x && in_y && in_z;
        cx_q  <= c_x[DIM_W-1:0];
        t_q   <= T_W'(c_y[DIM_W-1:0]) + T_W'(dim_y_q) * T_W'(c_z[DIM_W-1:0]);
      end
      ST_ACC_IDX2: begin
        ok_q   <= inr_q && (idx < IDX_W'(NUM_VOXELS));
        addr_q <= idx[AW-1:0];
      end
      ST_RD_RD: begin
        res_cnt_q   <= '0;
        res_valid_q <= 1'b0;
        for (int j = 0; j < N_AXES; j++) mean_q[j] <= '0;
        for (int j = 0; j < N_TERMS; j++) cov_q[j] <= '0;
      end
      ST_RD_LOAD: begin
        k_q         <= '0;
        ent_cnt_q   <= rd_cnt;
        res_cnt_q   <= CNT_OUT_W'(rd_cnt);
        res_valid_q <= ld_valid;
        for (int j = 0; j < N_AXES; j++) begin
          ent_s1_q[j] <= ram_rdata[S1_OFF + SUM1_W*j +: SUM1_W];
        end
        for (int j = 0; j < N_TERMS; j++) begin
          ent_s2_q[j] <= ram_rdata[S2_OFF + SUM2_W*j +: SUM2_W];
        end
      end
      ST_MEAN_WAIT: if (div_done) begin
        unique case (k_q)
          3'd0: mean_q[0] <= sat_mean(div_quo);
          3'd1: mean_q[1] <= sat_mean(div_quo);
          default: mean_q[2] <= sat_mean(div_quo);
        endcase
        k_q <= (k_q == K_W'(N_AXES - 1)) ? '0 : (k_q + 1'b1);
      end
      ST_PROD: prod_q <= ma * mb;
      ST_S2_WAIT: if (div_done) begin
        d_q <= clamp62(div_quo) - signed'({{(SUM2_W-SQ_W){prod_q[SQ_W-1]}}, prod_q});
      end
      ST_D_WAIT: if (div_done) begin
        unique case (k_q)
          3'd0: cov_q[0] <= sat_cov(d_q + div_quo);
          3'd1: cov_q[1] <= sat_cov(d_q + div_quo);
          3'd2: cov_q[2] <= sat_cov(d_q + div_quo);
          3'd3: cov_q[3] <= sat_cov(d_q + div_quo);
          3'd4: cov_q[4] <= sat_cov(d_q + div_quo);
          default: cov_q[5] <= sat_cov(d_q + div_quo);
        endcase
        k_q <= k_q + 1'b1;
      end
      ST_OUT: if (out_free) begin
        out_cnt_q <= res_cnt_q;
        out_vld_q <= res_valid_q;
        for (int j = 0; j < N_AXES; j++) out_mean_q[j] <= mean_q[j];
        for (int j = 0; j < N_TERMS; j++) out_cov_q[j] <= cov_q[j];
      end
      default: ;
    endcase
  end

  // Voxel store: count, coordinate sums and product sums in one word.
  vpma_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_VOXELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // Shared floor divider.
  vpma_div #(
    .DVS_W (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (ent_cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Result ports.
  assign out_valid_o   = out_valid_q;
  assign mean_x_o      = out_mean_q[0];
  assign mean_y_o      = out_mean_q[1];
  assign mean_z_o      = out_mean_q[2];
  assign cov_xx_o      = out_cov_q[0];
  assign cov_xy_o      = out_cov_q[1];
  assign cov_xz_o      = out_cov_q[2];
  assign cov_yy_o      = out_cov_q[3];
  assign cov_yz_o      = out_cov_q[4];
  assign cov_zz_o      = out_cov_q[5];
  assign point_count_o = out_cnt_q;
  assign voxel_valid_o = out_vld_q;

endmodule

// ===== rtl/core/vpma_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Voxel moment accumulator checker
// Port-level assertions on the accumulator, bound to the top level.
// ---------------------------------------------------------------------------
module vpma_checker import vpma_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_we_i,
  input logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input logic [CFG_DATA_W-1:0]    cfg_data_i,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     operation_i,
  input logic signed [COORD_W-1:0] point_x_i,
  input logic signed [COORD_W-1:0] point_y_i,
  input logic signed [COORD_W-1:0] point_z_i,
  input logic [VIDX_W-1:0]        voxel_index_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [MEAN_W-1:0] mean_x_o,
  input logic signed [MEAN_W-1:0] mean_y_o,
  input logic signed [MEAN_W-1:0] mean_z_o,
  input logic signed [COV_W-1:0]  cov_xx_o,
  input logic signed [COV_W-1:0]  cov_xy_o,
  input logic signed [COV_W-1:0]  cov_xz_o,
  input logic signed [COV_W-1:0]  cov_yy_o,
  input logic signed [COV_W-1:0]  cov_yz_o,
  input logic signed [COV_W-1:0]  cov_zz_o,
  input logic [CNT_OUT_W-1:0]     point_count_o,
  input logic                     voxel_valid_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One request at a time: the block is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // Requests wait for the clearing pass after reset.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("request taken during clearing pass");

  // An invalid voxel reports zeroed means and diagonal covariance terms.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !voxel_valid_o |->
      mean_x_o == '0 && mean_y_o == '0 && mean_z_o == '0 &&
      cov_xx_o == '0 && cov_yy_o == '0 && cov_zz_o == '0)
    else $error("invalid voxel with nonzero statistics");

endmodule

bind voxel_point_moment_accumulator vpma_checker u_vpma_checker (.*);

// ===== sim/voxel_point_moment_accumulator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Voxel point moment accumulator testbench
// Streams point and read requests into the accumulator and mirrors the voxel
// store in a behavioral predictor. Each read result is checked field by field
// against the predicted mean, covariance, count and valid flag.
// ---------------------------------------------------------------------------
module voxel_point_moment_accumulator_tb;
  import vpma_pkg::*;

  localparam int unsigned NVOX        = NUM_VOXELS_DEF;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned SETTLE      = 20;

  // Result fields of one voxel read, packed for the expectation queue.
  typedef struct packed {
    logic [2:0][MEAN_W-1:0] mean;
    logic [5:0][COV_W-1:0]  cov;
    logic [CNT_OUT_W-1:0]   count;
    logic                   valid;
  } voxel_stats_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  op_e                      req_op;
  logic signed [COORD_W-1:0] req_x;
  logic signed [COORD_W-1:0] req_y;
  logic signed [COORD_W-1:0] req_z;
  logic [VIDX_W-1:0]        req_index;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [MEAN_W-1:0] mean_x, mean_y, mean_z;
  logic signed [COV_W-1:0]  cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz;
  logic [CNT_OUT_W-1:0]     point_count;
  logic                     voxel_valid;

  // Predictor copy of the configuration and voxel store.
  logic [LEAF_W-1:0]        leaf_recip;
  logic signed [ORG_W-1:0]  grid_org [3];
  logic [DIM_W-1:0]         grid_dim [3];
  logic [MINP_W-1:0]        min_count;
  logic [15:0]              voxel_count [NVOX];
  logic [SUM1_W-1:0]        coord_sum [3][NVOX];
  logic [SUM2_W-1:0]        product_sum [6][NVOX];

  voxel_stats_t             stats_expected [$];
  int unsigned              errors = 0;
  int unsigned              tx_idle_pct;
  int unsigned              rx_idle_pct;
  int unsigned              quiet_cycles = 0;
  int                       grid_shift;
  bit                       grid_aligned;

  voxel_point_moment_accumulator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (req_op),
    .point_x_i     (req_x),
    .point_y_i     (req_y),
    .point_z_i     (req_z),
    .voxel_index_i (req_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .mean_x_o      (mean_x),
    .mean_y_o      (mean_y),
    .mean_z_o      (mean_z),
    .cov_xx_o      (cov_xx),
    .cov_xy_o      (cov_xy),
    .cov_xz_o      (cov_xz),
    .cov_yy_o      (cov_yy),
    .cov_yz_o      (cov_yz),
    .cov_zz_o      (cov_zz),
    .point_count_o (point_count),
    .voxel_valid_o (voxel_valid)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Floor division by a positive divisor.
  function automatic longint floor_div(input longint a, input longint n);
    longint q;
    q = a / n;
    if (a < 0 && (a % n) != 0) q = q - 1;
    return q;
  endfunction

  // Saturate a signed value to w bits.
  function automatic longint sat_to(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Bin one point into the predicted store; dropped points change nothing.
  task automatic bin_point(input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py,
                           input logic signed [COORD_W-1:0] pz);
    longint p [3];
    longint c [3];
    longint vidx;
    bit     inside_grid;
    p[0] = longint'(px);
    p[1] = longint'(py);
    p[2] = longint'(pz);
    inside_grid = 1'b1;
    for (int a = 0; a < 3; a++) begin
      c[a] = ((p[a] * longint'(leaf_recip)) >>> 24) - longint'(grid_org[a]);
      if (c[a] < 0 || c[a] >= longint'(grid_dim[a])) inside_grid = 1'b0;
    end
    if (!inside_grid) return;
    vidx = c[0] + longint'(grid_dim[0]) * (c[1] + longint'(grid_dim[1]) * c[2]);
    if (vidx >= NVOX) return;
    if (voxel_count[vidx] == 16'hFFFF) return;
    voxel_count[vidx] = voxel_count[vidx] + 16'd1;
    for (int a = 0; a < 3; a++) coord_sum[a][vidx] = coord_sum[a][vidx] + p[a][SUM1_W-1:0];
    for (int k = 0; k < 6; k++)
      product_sum[k][vidx] = product_sum[k][vidx] + 64'(p[term_a(k)] * p[term_b(k)]);
  endtask

  // Work out the statistics of one voxel read, then clear the voxel.
  task automatic read_voxel_stats(input logic [VIDX_W-1:0] vidx);
    voxel_stats_t s;
    longint n;
    longint m [3];
    longint d;
    s = '0;
    n = longint'(voxel_count[vidx]);
    s.count = voxel_count[vidx];
    s.valid = (voxel_count[vidx] >= min_count);
    if (s.valid && n > 0) begin
      for (int a = 0; a < 3; a++) begin
        m[a] = sat_to(floor_div(longint'($signed(coord_sum[a][vidx])), n), MEAN_W);
        s.mean[a] = m[a][MEAN_W-1:0];
      end
      for (int k = 0; k < 6; k++) begin
        d = floor_div($signed(product_sum[k][vidx]), n);
        if (d > (longint'(1) <<< 62)) d = longint'(1) <<< 62;
        if (d < -(longint'(1) <<< 62)) d = -(longint'(1) <<< 62);
        d = d - m[term_a(k)] * m[term_b(k)];
        s.cov[k] = COV_W'(sat_to(d + floor_div(-d, n), COV_W));
      end
    end
    voxel_count[vidx] = '0;
    for (int a = 0; a < 3; a++) coord_sum[a][vidx] = '0;
    for (int k = 0; k < 6; k++) product_sum[k][vidx] = '0;
    stats_expected.push_back(s);
  endtask

  // Send one request, holding it until the block takes it.
  task automatic send_request(input op_e op, input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic signed [COORD_W-1:0] pz,
                              input logic [VIDX_W-1:0] vidx);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid  <= 1'b1;
    req_op    <= op;
    req_x     <= px;
    req_y     <= py;
    req_z     <= pz;
    req_index <= vidx;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (op == OP_ACCUM) bin_point(px, py, pz);
    else read_voxel_stats(vidx);
  endtask

  task automatic push_point(input int px, input int py, input int pz);
    send_request(OP_ACCUM, px[COORD_W-1:0], py[COORD_W-1:0], pz[COORD_W-1:0],
                 VIDX_W'($urandom));
  endtask

  task automatic read_voxel(input int vidx);
    send_request(OP_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 vidx[VIDX_W-1:0]);
  endtask

  // Stop requesting and wait until every expected result has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Register write, mirrored in the predictor.
  task automatic set_reg(input cfg_idx_e r, input int unsigned v);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
    case (r)
      CFG_INV_LEAF:   leaf_recip  = v[LEAF_W-1:0];
      CFG_ORIGIN_X:   grid_org[0] = v[ORG_W-1:0];
      CFG_ORIGIN_Y:   grid_org[1] = v[ORG_W-1:0];
      CFG_ORIGIN_Z:   grid_org[2] = v[ORG_W-1:0];
      CFG_DIM_X:      grid_dim[0] = v[DIM_W-1:0];
      CFG_DIM_Y:      grid_dim[1] = v[DIM_W-1:0];
      CFG_DIM_Z:      grid_dim[2] = v[DIM_W-1:0];
      CFG_MIN_POINTS: min_count   = v[MINP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int unsigned leaf, input int ox, input int oy, input int oz,
                          input int unsigned dx, input int unsigned dy,
                          input int unsigned dz, input int unsigned minp);
    set_reg(CFG_INV_LEAF, leaf);
    set_reg(CFG_ORIGIN_X, ox);
    set_reg(CFG_ORIGIN_Y, oy);
    set_reg(CFG_ORIGIN_Z, oz);
    set_reg(CFG_DIM_X, dx);
    set_reg(CFG_DIM_Y, dy);
    set_reg(CFG_DIM_Z, dz);
    set_reg(CFG_MIN_POINTS, minp);
  endtask

  // Default grid: valid, too-few-point, empty and out-of-grid cases.
  task automatic test_default_grid();
    push_point(384, 640, 896);
    push_point(511, 512, 768);
    push_point(256, 767, 1023);
    push_point(300, 600, 900);
    read_voxel(1 + 16 * 2 + 256 * 3);
    push_point(5 * 256, 0, 0);
    push_point(5 * 256 + 255, 255, 255);
    read_voxel(5);
    read_voxel(4095);
    push_point(-1, 0, 0);
    push_point(16 * 256, 0, 0);
    read_voxel(0);
    wait_results_done();
  endtask

  // Register extremes and the extremes of the point fields.
  task automatic test_register_extremes();
    set_grid(1, -1, -1, -1, 2, 2, 2, 0);
    push_point(-8388608, -8388608, -8388608);
    push_point(8388607, 8388607, 8388607);
    push_point(8388607, -8388608, 8388607);
    push_point(-8388608, 8388607, -8388608);
    read_voxel(0);
    read_voxel(7);
    read_voxel(5);
    read_voxel(2);
    read_voxel(3);
    wait_results_done();
    set_grid(16777215, 32767, -32768, 0, 4096, 1, 1, 65535);
    push_point(32768, -32768, 1);
    push_point(8388607, -32768, 1);
    read_voxel(0);
    wait_results_done();
    // A zero dimension leaves no room for any point.
    set_grid(65536, 0, 0, 0, 4096, 2, 0, 0);
    push_point(0, 0, 0);
    read_voxel(0);
    wait_results_done();
    // A flat index past the store is dropped.
    set_reg(CFG_DIM_Z, 1);
    push_point(4095 * 256, 256, 0);
    push_point(4095 * 256, 0, 0);
    read_voxel(4095);
    wait_results_done();
  endtask

  // Pick a grid: mostly power-of-two leaves around small origins.
  task automatic randomize_grid();
    int unsigned leaf;
    grid_aligned = ($urandom_range(0, 4) != 0);
    if (grid_aligned) begin
      grid_shift = int'($urandom_range(0, 8)) - 4;
      leaf = (grid_shift >= 0) ? (65536 << grid_shift) : (65536 >> -grid_shift);
      set_grid(leaf, int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
               int'($urandom_range(0, 8)) - 4, $urandom_range(1, 16), $urandom_range(1, 16),
               $urandom_range(1, 16), $urandom_range(0, 5));
    end else begin
      set_grid($urandom_range(1, 16777215), $urandom, $urandom, $urandom,
               $urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 4096),
               $urandom_range(0, 65535));
    end
  endtask

  // Coordinate that lands inside the grid along one axis.
  function automatic int grid_coord(input int a);
    int leaf_len;
    leaf_len = 1 << (8 - grid_shift);
    return (int'($urandom_range(0, grid_dim[a] - 1)) + int'(grid_org[a])) * leaf_len
           + int'($urandom_range(0, leaf_len - 1));
  endfunction

  task automatic test_random_traffic(input int unsigned n);
    int unsigned span;
    span = grid_dim[0] * grid_dim[1] * grid_dim[2];
    if (span > NVOX || span == 0) span = NVOX;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 7) == 0) read_voxel($urandom_range(0, NVOX - 1));
        else read_voxel($urandom_range(0, span - 1));
      end else if (grid_aligned && $urandom_range(0, 99) < 85) begin
        push_point(grid_coord(0), grid_coord(1), grid_coord(2));
      end else begin
        push_point($urandom, $urandom, $urandom);
      end
    end
    wait_results_done();
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk_i) begin
    voxel_stats_t got;
    voxel_stats_t want;
    if (rst_ni && out_valid && !out_stall) begin
      got.mean  = {mean_z, mean_y, mean_x};
      got.cov   = {cov_zz, cov_yz, cov_yy, cov_xz, cov_xy, cov_xx};
      got.count = point_count;
      got.valid = voxel_valid;
      if (stats_expected.size() == 0) begin
        errors++;
        $display("%0t unexpected result: count %0d valid %0d", $time, got.count, got.valid);
      end else begin
        want = stats_expected.pop_front();
        for (int a = 0; a < 3; a++)
          if (got.mean[a] !== want.mean[a]) begin
            errors++;
            $display("%0t mean[%0d] mismatch: expected %0d actual %0d", $time, a,
                     $signed(want.mean[a]), $signed(got.mean[a]));
          end
        for (int k = 0; k < 6; k++)
          if (got.cov[k] !== want.cov[k]) begin
            errors++;
            $display("%0t cov term %0d mismatch: expected %0d actual %0d", $time, k,
                     $signed(want.cov[k]), $signed(got.cov[k]));
          end
        if (got.count !== want.count) begin
          errors++;
          $display("%0t point_count mismatch: expected %0d actual %0d", $time,
                   want.count, got.count);
        end
        if (got.valid !== want.valid) begin
          errors++;
          $display("%0t voxel_valid mismatch: expected %0d actual %0d", $time,
                   want.valid, got.valid);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or a result.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tx_idle_pct  = 26;
    rx_idle_pct  = 50;
    grid_shift   = 0;
    grid_aligned = 1'b1;
    leaf_recip   = 24'd65536;
    min_count    = 16'd3;
    for (int a = 0; a < 3; a++) begin
      grid_org[a] = '0;
      grid_dim[a] = 13'd16;
    end
    for (int i = 0; i < NVOX; i++) begin
      voxel_count[i] = '0;
      for (int a = 0; a < 3; a++) coord_sum[a][i] = '0;
      for (int k = 0; k < 6; k++) product_sum[k][i] = '0;
    end
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    req_op    = OP_ACCUM;
    req_x     = '0;
    req_y     = '0;
    req_z     = '0;
    req_index = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_grid();
    test_register_extremes();

    // Random traffic under three idling patterns.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 26 : ((phase == 1) ? 50 : 0);
      rx_idle_pct = (phase == 0) ? 50 : ((phase == 1) ? 26 : 0);
      for (int g = 0; g < 2; g++) begin
        randomize_grid();
        test_random_traffic(240);
      end
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
